// File: rtl/irr_pkg.sv
`timescale 1ns / 1ps

package irr_pkg;

   // Default depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_SIZE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEP_TIME   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LEN    = 2'd2;

   localparam logic [11:0] MAX_LEN_RESET = 12'hFFF;

   // Protocol control information: frame type nibble.
   localparam logic [3:0] PCI_SINGLE = 4'h0;
   localparam logic [3:0] PCI_FIRST  = 4'h1;
   localparam logic [3:0] PCI_CONSEC = 4'h2;

   // Flow-control status nibble.
   localparam logic [3:0] FC_CONTINUE = 4'h0;
   localparam logic [3:0] FC_OVERFLOW = 4'h2;

   // Error codes of a result.
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_SEQ     = 2'd1;
   localparam logic [1:0] ERR_OVF     = 2'd2;
   localparam logic [1:0] ERR_INVALID = 2'd3;

   typedef struct packed {
      logic [63:0] frame_bytes;
      logic [3:0]  frame_len;
   } irr_req_type;

   typedef struct packed {
      logic [55:0] payload;
      logic [2:0]  payload_count;
      logic        msg_start;
      logic        msg_end;
      logic [11:0] msg_length;
      logic        fc_send;
      logic [63:0] fc_frame;
      logic [1:0]  error_code;
   } irr_rsp_type;

   typedef struct packed {
      logic [7:0]  fc_block_len;
      logic [7:0]  sep_time;
      logic [11:0] max_len;
   } irr_cfg_type;

   typedef enum logic [2:0] {
      CMD_IGNORE,
      CMD_INVALID,
      CMD_SINGLE,
      CMD_FIRST,
      CMD_OVERFLOW,
      CMD_CONSEC
   } irr_cmd_kind_type;

   // Classified frame handed from front to back.
   typedef struct packed {
      irr_cmd_kind_type kind;
      logic [3:0]       nib;
      logic [2:0]       len_m1;
      logic [11:0]      length;
      logic [55:0]      data;
   } irr_cmd_type;

   // Keep the first count bytes of a top-aligned payload, zero the rest.
   function automatic logic [55:0] mask_bytes(input logic [55:0] data,
                                              input logic [2:0]  count);
      logic [55:0] result;
      result = '0;
      for (int i = 0; i < 7; i++) begin
         if (3'(i) < count) begin
            result[55-8*i -: 8] = data[55-8*i -: 8];
         end
      end
      return result;
   endfunction

   function automatic logic [63:0] make_fc(input logic [3:0] status,
                                           input logic [7:0] bs_byte,
                                           input logic [7:0] sep_time);
      return {4'h3, status, bs_byte, sep_time, 40'hFF_FFFF_FFFF};
   endfunction

endpackage

// File: rtl/irr_front.sv
`timescale 1ns / 1ps

module irr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  irr_pkg::irr_req_type req_item,
   input  irr_pkg::irr_cfg_type cfg,
   output logic                 push,
   output irr_pkg::irr_cmd_type push_cmd,
   input  logic                 queue_full
);

   logic                 valid_ff, valid_in;
   irr_pkg::irr_cmd_type cmd_ff, cmd_in;
   logic                 accept;

   logic [3:0]  len_clip;
   logic [3:0]  kind;
   logic [3:0]  nib;
   logic [11:0] dl;

   assign req_stall = valid_ff && queue_full;
   assign accept    = req_valid && !req_stall;
   assign push      = valid_ff && !queue_full;
   assign push_cmd  = cmd_ff;

   assign len_clip = (req_item.frame_len > 4'd8) ? 4'd8 : req_item.frame_len;
   assign kind     = req_item.frame_bytes[63:60];
   assign nib      = req_item.frame_bytes[59:56];
   assign dl       = {nib, req_item.frame_bytes[55:48]};

   // Classify the frame; state-dependent checks are left to the back end.
   always_comb begin
      cmd_in        = '0;
      cmd_in.kind   = irr_pkg::CMD_IGNORE;
      cmd_in.nib    = nib;
      cmd_in.len_m1 = 3'(len_clip - 4'd1);
      cmd_in.length = dl;
      cmd_in.data   = req_item.frame_bytes[55:0];
      if (len_clip != 4'd0) begin
         case (kind)
            irr_pkg::PCI_SINGLE: begin
               if (nib == 4'd0 || nib > 4'd7 || nib > (len_clip - 4'd1)) begin
                  cmd_in.kind = irr_pkg::CMD_INVALID;
               end else begin
                  cmd_in.kind = irr_pkg::CMD_SINGLE;
               end
            end
            irr_pkg::PCI_FIRST: begin
               cmd_in.data = {req_item.frame_bytes[47:0], 8'h00};
               if (len_clip < 4'd8 || dl < 12'd8) begin
                  cmd_in.kind = irr_pkg::CMD_INVALID;
               end else if (dl > cfg.max_len) begin
                  cmd_in.kind = irr_pkg::CMD_OVERFLOW;
               end else begin
                  cmd_in.kind = irr_pkg::CMD_FIRST;
               end
            end
            irr_pkg::PCI_CONSEC: begin
               cmd_in.kind = irr_pkg::CMD_CONSEC;
            end
            default: begin
               cmd_in.kind = irr_pkg::CMD_IGNORE;
            end
         endcase
      end
   end

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// File: rtl/irr_queue.sv
`timescale 1ns / 1ps

module irr_queue #(
   parameter int DEPTH = irr_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  irr_pkg::irr_cmd_type push_cmd,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output irr_pkg::irr_cmd_type head_cmd
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   irr_pkg::irr_cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/irr_back.sv
`timescale 1ns / 1ps

module irr_back (
   input  logic                 clock,
   input  logic                 reset,
   input  irr_pkg::irr_cfg_type cfg,
   input  logic                 head_valid,
   input  irr_pkg::irr_cmd_type head_cmd,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output irr_pkg::irr_rsp_type rsp_item
);

   typedef struct packed {
      logic        receiving;
      logic [3:0]  expected_seq;
      logic [11:0] received_count;
      logic [11:0] msg_total;
      logic [7:0]  frames_in_block;
   } irr_rx_type;

   irr_rx_type           rx_ff, rx_in;
   logic                 out_valid_ff, out_valid_in;
   irr_pkg::irr_rsp_type out_ff, out_in;

   logic [11:0] remaining;
   logic [2:0]  take;
   logic [11:0] received_next;
   logic [7:0]  block_next;

   assign pop       = head_valid && (!out_valid_ff || !rsp_stall);
   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   assign remaining     = rx_ff.msg_total - rx_ff.received_count;
   assign take          = (remaining > 12'd7) ? 3'd7 : remaining[2:0];
   assign received_next = rx_ff.received_count + {9'd0, take};
   assign block_next    = rx_ff.frames_in_block + 8'd1;

   always_comb begin
      rx_in  = rx_ff;
      out_in = '0;
      case (head_cmd.kind)
         irr_pkg::CMD_IGNORE: begin
         end
         irr_pkg::CMD_INVALID: begin
            out_in.error_code = irr_pkg::ERR_INVALID;
         end
         irr_pkg::CMD_SINGLE: begin
            rx_in                = '0;
            out_in.payload       = irr_pkg::mask_bytes(head_cmd.data, head_cmd.nib[2:0]);
            out_in.payload_count = head_cmd.nib[2:0];
            out_in.msg_start     = 1'b1;
            out_in.msg_end       = 1'b1;
            out_in.msg_length    = {8'd0, head_cmd.nib};
         end
         irr_pkg::CMD_OVERFLOW: begin
            rx_in             = '0;
            out_in.fc_send    = 1'b1;
            out_in.fc_frame   = irr_pkg::make_fc(irr_pkg::FC_OVERFLOW,
                                                 cfg.fc_block_len, cfg.sep_time);
            out_in.error_code = irr_pkg::ERR_OVF;
         end
         irr_pkg::CMD_FIRST: begin
            rx_in.receiving       = 1'b1;
            rx_in.expected_seq    = 4'd1;
            rx_in.received_count  = 12'd6;
            rx_in.msg_total       = head_cmd.length;
            rx_in.frames_in_block = 8'd0;
            out_in.payload        = head_cmd.data;
            out_in.payload_count  = 3'd6;
            out_in.msg_start      = 1'b1;
            out_in.msg_length     = head_cmd.length;
            out_in.fc_send        = 1'b1;
            out_in.fc_frame       = irr_pkg::make_fc(irr_pkg::FC_CONTINUE,
                                                     cfg.fc_block_len, cfg.sep_time);
         end
         irr_pkg::CMD_CONSEC: begin
            if (!rx_ff.receiving || head_cmd.nib != rx_ff.expected_seq) begin
               rx_in             = '0;
               out_in.error_code = irr_pkg::ERR_SEQ;
            end else if (take > head_cmd.len_m1) begin
               out_in.error_code = irr_pkg::ERR_INVALID;
            end else begin
               out_in.payload       = irr_pkg::mask_bytes(head_cmd.data, take);
               out_in.payload_count = take;
               rx_in.received_count = received_next;
               if (received_next >= rx_ff.msg_total) begin
                  out_in.msg_end = 1'b1;
                  rx_in          = '0;
               end else begin
                  rx_in.expected_seq = rx_ff.expected_seq + 4'd1;
                  if (cfg.fc_block_len != 8'd0) begin
                     rx_in.frames_in_block = block_next;
                     if (block_next >= cfg.fc_block_len) begin
                        rx_in.frames_in_block = 8'd0;
                        out_in.fc_send        = 1'b1;
                        out_in.fc_frame       = irr_pkg::make_fc(irr_pkg::FC_CONTINUE,
                                                                 cfg.fc_block_len,
                                                                 cfg.sep_time);
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (pop) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            rx_ff <= rx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= out_in;
      end
   end

endmodule

// File: rtl/isotp_receive_reassembler.sv
// A frame is held in the front register, then in a queue entry, and its result is loaded
// into the output register, where it stays until it is taken.
// Throughput: one frame per cycle while the output is not stalled.
// Every accepted frame yields exactly one result item, ignored frames included.
// Reset (synchronous, active high) returns reception to idle, empties the queue and
// restores block size 0, separation time 0 and maximum message length 4095.
`timescale 1ns / 1ps

module isotp_receive_reassembler #(
   parameter int QUEUE_DEPTH = irr_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   // frame input
   input  logic                               req_valid,
   output logic                               req_stall,
   input  irr_pkg::irr_req_type               req_item,
   // result output
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output irr_pkg::irr_rsp_type               rsp_item,
   // configuration writes
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [irr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [irr_pkg::CSR_DATA_W-1:0]     csr_data
);

   // Configuration registers. Writes must arrive only while the block is idle;
   // this is not enforced, and front and back read them directly without a shadow copy.
   irr_pkg::irr_cfg_type cfg_ff, cfg_in;

   // Front to queue
   logic                 push;
   irr_pkg::irr_cmd_type push_cmd;
   logic                 queue_full;

   // Queue to back
   logic                 pop;
   logic                 head_valid;
   irr_pkg::irr_cmd_type head_cmd;

   // Always ready: a write is a single register update.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            irr_pkg::CSR_BLOCK_SIZE: cfg_in.fc_block_len = csr_data[7:0];
            irr_pkg::CSR_SEP_TIME:   cfg_in.sep_time     = csr_data[7:0];
            irr_pkg::CSR_MAX_LEN:    cfg_in.max_len      = csr_data[11:0];
            default: begin
               // drop writes to unmapped indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fc_block_len <= 8'd0;
         cfg_ff.sep_time     <= 8'd0;
         cfg_ff.max_len      <= irr_pkg::MAX_LEN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: take the frame, clip its length, classify it and check the
   // length fields that do not depend on reception state.
   irr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .cfg        (cfg_ff),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   // Short queue: hold classified items so front and back stall independently.
   irr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Back: advance the reassembly state, build the result and the
   // flow-control frame, and hold it in the output register until taken.
   irr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_item   (rsp_item)
   );

endmodule

// File: bench/isotp_receive_reassembler_tb.sv
`timescale 1ns / 1ps

module isotp_receive_reassembler_tb;
   import irr_pkg::*;

   // Frame type nibble of a received flow-control frame (ignored on the receive side).
   localparam logic [3:0] PCI_FLOW = 4'h3;
   localparam int CAN_FRAME_BYTES  = 8;
   localparam int LONG_HOLD_CYCLES = 64;
   localparam int SETTLE_CYCLES    = 8;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int REPORT_LINES     = 40;
   localparam int PHASES           = 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   irr_req_type req_item = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   irr_rsp_type rsp_item;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   isotp_receive_reassembler dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Register copies and reception state of the predictor.
   logic [7:0]  cfg_fc_block;
   logic [7:0]  cfg_sep_time;
   logic [11:0] cfg_max_len;
   logic        rx_active;
   logic [3:0]  rx_seq;
   logic [11:0] rx_count;
   logic [11:0] rx_total;
   logic [7:0]  rx_block_frames;

   irr_req_type frames_to_send[$];
   irr_rsp_type expected_results[$];

   // Handshake flags seen at the last rising edge, read by the drivers at the falling edge.
   logic req_fired = 1'b0;
   logic rsp_fired = 1'b0;
   int   send_wait = 0;
   int   rsp_wait_left = 0;
   int   sender_gap_max = 3;
   int   receiver_gap_max = 3;
   int   hold_requests = 0;
   int   hold_served = 0;

   int unsigned cycle_count = 0;
   int frames_queued = 0;
   int frames_accepted = 0;
   int results_checked = 0;
   int messages_done = 0;
   int fc_requests = 0;
   int settings_used = 1;
   int mismatch_count = 0;
   int error_tally[4] = '{0, 0, 0, 0};

   // ---------------------------------------------------------------- predictor

   function automatic void drop_reception();
      rx_active = 1'b0;
      rx_seq = '0;
      rx_count = '0;
      rx_total = '0;
      rx_block_frames = '0;
   endfunction

   function automatic void reset_model();
      cfg_fc_block = '0;
      cfg_sep_time = '0;
      cfg_max_len = MAX_LEN_RESET;
      drop_reception();
   endfunction

   // Bytes first .. first+count-1 of a frame, packed at the top, the rest cleared.
   function automatic logic [55:0] pick_bytes(input logic [63:0] frame, input int first,
                                             input int count);
      logic [63:0] shifted;
      logic [55:0] picked;
      shifted = frame << (8 * first);
      picked = shifted[63:8];
      for (int i = count; i < 7; i++) begin
         picked[55-8*i -: 8] = 8'h00;
      end
      return picked;
   endfunction

   function automatic logic [63:0] flow_control(input logic [3:0] status);
      return {8'h30 | {4'h0, status}, cfg_fc_block, cfg_sep_time, {5{8'hFF}}};
   endfunction

   // Work out the result of one received frame and advance the reception state.
   function automatic irr_rsp_type reassemble(input irr_req_type frame);
      irr_rsp_type r;
      int          flen;
      logic [3:0]  kind;
      logic [3:0]  nib;
      logic [11:0] declared;
      logic [11:0] bytes_due;
      logic [11:0] take;
      r = '0;
      flen = (frame.frame_len > 4'd8) ? CAN_FRAME_BYTES : int'(frame.frame_len);
      kind = frame.frame_bytes[63:60];
      nib = frame.frame_bytes[59:56];
      declared = {nib, frame.frame_bytes[55:48]};
      if (flen == 0) return r;
      case (kind)
         PCI_SINGLE: begin
            if (nib == 4'd0 || nib > 4'd7 || int'(nib) > flen - 1) begin
               r.error_code = ERR_INVALID;
            end else begin
               // a single frame silently drops any reception in progress
               drop_reception();
               r.payload = pick_bytes(frame.frame_bytes, 1, int'(nib));
               r.payload_count = nib[2:0];
               r.msg_start = 1'b1;
               r.msg_end = 1'b1;
               r.msg_length = {8'd0, nib};
            end
         end
         PCI_FIRST: begin
            if (flen < CAN_FRAME_BYTES || declared < 12'd8) begin
               r.error_code = ERR_INVALID;
            end else begin
               drop_reception();
               if (declared > cfg_max_len) begin
                  r.fc_send = 1'b1;
                  r.fc_frame = flow_control(FC_OVERFLOW);
                  r.error_code = ERR_OVF;
               end else begin
                  rx_active = 1'b1;
                  rx_total = declared;
                  rx_count = 12'd6;
                  rx_seq = 4'd1;
                  r.payload = pick_bytes(frame.frame_bytes, 2, 6);
                  r.payload_count = 3'd6;
                  r.msg_start = 1'b1;
                  r.msg_length = declared;
                  r.fc_send = 1'b1;
                  r.fc_frame = flow_control(FC_CONTINUE);
               end
            end
         end
         PCI_CONSEC: begin
            if (!rx_active || nib != rx_seq) begin
               drop_reception();
               r.error_code = ERR_SEQ;
            end else begin
               bytes_due = rx_total - rx_count;
               take = (bytes_due > 12'd7) ? 12'd7 : bytes_due;
               if (int'(take) > flen - 1) begin
                  // too short to carry what is due: ignore, keep the state
                  r.error_code = ERR_INVALID;
               end else begin
                  r.payload = pick_bytes(frame.frame_bytes, 1, int'(take));
                  r.payload_count = take[2:0];
                  rx_count = rx_count + take;
                  if (rx_count >= rx_total) begin
                     r.msg_end = 1'b1;
                     drop_reception();
                  end else begin
                     rx_seq = rx_seq + 4'd1;
                     if (cfg_fc_block != 8'd0) begin
                        rx_block_frames = rx_block_frames + 8'd1;
                        if (rx_block_frames >= cfg_fc_block) begin
                           rx_block_frames = '0;
                           r.fc_send = 1'b1;
                           r.fc_frame = flow_control(FC_CONTINUE);
                        end
                     end
                  end
               end
            end
         end
         default: begin
            // flow-control frames and reserved types pass as an all-zero result
         end
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (mismatch_count < REPORT_LINES) begin
         $display("mismatch at result %0d, %s: got %h, expected %h",
                  results_checked, what, got, want);
      end
      mismatch_count++;
   endtask

   task automatic compare_result(input irr_rsp_type got, input irr_rsp_type want);
      if (got.payload !== want.payload)
         report_mismatch("payload", 64'(got.payload), 64'(want.payload));
      if (got.payload_count !== want.payload_count)
         report_mismatch("payload_count", 64'(got.payload_count), 64'(want.payload_count));
      if (got.msg_start !== want.msg_start)
         report_mismatch("msg_start", 64'(got.msg_start), 64'(want.msg_start));
      if (got.msg_end !== want.msg_end)
         report_mismatch("msg_end", 64'(got.msg_end), 64'(want.msg_end));
      if (got.msg_length !== want.msg_length)
         report_mismatch("msg_length", 64'(got.msg_length), 64'(want.msg_length));
      if (got.fc_send !== want.fc_send)
         report_mismatch("fc_send", 64'(got.fc_send), 64'(want.fc_send));
      if (got.fc_frame !== want.fc_frame)
         report_mismatch("fc_frame", got.fc_frame, want.fc_frame);
      if (got.error_code !== want.error_code)
         report_mismatch("error_code", 64'(got.error_code), 64'(want.error_code));
   endtask

   // Predict on every accepted frame, then check every accepted result in order.
   always @(posedge clock) begin
      irr_rsp_type want;
      req_fired <= !reset && req_valid && !req_stall;
      rsp_fired <= !reset && rsp_valid && !rsp_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            expected_results.push_back(reassemble(req_item));
            frames_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_item.fc_frame, '0);
            end else begin
               want = expected_results.pop_front();
               compare_result(rsp_item, want);
               if (want.msg_end) messages_done++;
               if (want.fc_send) fc_requests++;
               error_tally[want.error_code]++;
            end
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles with %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- drivers

   // Frame sender: hold a stalled item, otherwise sit out the drawn gap and offer the next.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_fired) begin
         // hold: the item has not been taken yet
      end else if (send_wait > 0) begin
         req_valid <= 1'b0;
         send_wait <= send_wait - 1;
      end else if (frames_to_send.size() != 0) begin
         req_item <= frames_to_send.pop_front();
         req_valid <= 1'b1;
         send_wait <= $urandom_range(0, sender_gap_max);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Result receiver: stall for a drawn number of cycles after each result; on request
   // hold off for a long stretch so that the block backs up into its input.
   always @(negedge clock) begin
      int wait_cycles;
      wait_cycles = rsp_wait_left;
      if (rsp_fired) wait_cycles = $urandom_range(0, receiver_gap_max);
      if (hold_served != hold_requests) wait_cycles = LONG_HOLD_CYCLES;
      hold_served <= hold_requests;
      if (wait_cycles > 0) begin
         rsp_stall <= 1'b1;
         rsp_wait_left <= wait_cycles - 1;
      end else begin
         rsp_stall <= 1'b0;
         rsp_wait_left <= 0;
      end
   end

   // Write one register and mirror it in the predictor once the write is taken.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_BLOCK_SIZE: cfg_fc_block = value[7:0];
         CSR_SEP_TIME:   cfg_sep_time = value[7:0];
         CSR_MAX_LEN:    cfg_max_len = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Let every queued frame go and every result come back, then settle.
   task automatic drain();
      do @(posedge clock);
      while (frames_to_send.size() != 0 || req_valid || expected_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- stimulus

   function automatic logic [63:0] random_bytes();
      return {$urandom, $urandom};
   endfunction

   function automatic void queue_frame(input logic [63:0] bytes, input logic [3:0] flen);
      irr_req_type f;
      f.frame_bytes = bytes;
      f.frame_len = flen;
      frames_to_send.push_back(f);
      frames_queued++;
   endfunction

   // Mostly a full eight-byte frame, sometimes any length long enough for the data, now and then over-long.
   function automatic logic [3:0] frame_len_for(input int carried);
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return 4'(CAN_FRAME_BYTES);
      if (pick < 9) return 4'($urandom_range(carried + 1, CAN_FRAME_BYTES));
      return 4'($urandom_range(CAN_FRAME_BYTES + 1, 15));
   endfunction

   function automatic logic [63:0] first_frame(input int declared);
      logic [63:0] bytes;
      bytes = random_bytes();
      bytes[63:48] = {PCI_FIRST, 12'(declared)};
      return bytes;
   endfunction

   function automatic logic [63:0] consec_frame(input logic [3:0] seq);
      logic [63:0] bytes;
      bytes = random_bytes();
      bytes[63:56] = {PCI_CONSEC, seq};
      return bytes;
   endfunction

   function automatic void queue_single();
      int n;
      logic [63:0] bytes;
      n = $urandom_range(1, 7);
      bytes = random_bytes();
      bytes[63:56] = {PCI_SINGLE, 4'(n)};
      queue_frame(bytes, frame_len_for(n));
   endfunction

   function automatic void queue_noise();
      queue_frame(random_bytes(), 4'($urandom_range(0, 15)));
   endfunction

   // One first frame and its consecutive frames; unless clean, now and then break the
   // sequence with a wrong number, a short frame, a stray frame or a new message.
   function automatic void queue_message(input int declared, input bit clean);
      int bytes_due;
      int take;
      logic [3:0] seq;
      queue_frame(first_frame(declared), frame_len_for(7));
      if (12'(declared) > cfg_max_len) return;
      bytes_due = declared - 6;
      seq = 4'd1;
      while (bytes_due > 0) begin
         take = (bytes_due > 7) ? 7 : bytes_due;
         if (!clean && $urandom_range(0, 39) == 0) begin
            case ($urandom_range(0, 3))
               0: begin
                  queue_frame(consec_frame(seq ^ 4'($urandom_range(1, 15))), 4'd8);
                  return;
               end
               1: queue_frame(consec_frame(seq), 4'($urandom_range(1, take)));
               2: queue_noise();
               default: begin
                  queue_single();
                  return;
               end
            endcase
         end else begin
            queue_frame(consec_frame(seq), frame_len_for(take));
            bytes_due -= take;
            seq = seq + 4'd1;
         end
      end
   endfunction

   function automatic void queue_mixed();
      int pick;
      int declared;
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
         pick = $urandom_range(0, 9);
         if (pick < 6 || cfg_max_len > 12'd300) begin
            declared = (pick < 8) ? $urandom_range(8, 48) : $urandom_range(49, 200);
         end else if (pick < 8) begin
            declared = $urandom_range(49, 200);
         end else if (pick == 8) begin
            declared = cfg_max_len + $urandom_range(1, 30);
         end else begin
            declared = cfg_max_len;
         end
         if (declared > 4095) declared = 4095;
         if (declared < 8) declared = 8;
         queue_message(declared, 1'b0);
      end else if (pick < 17) begin
         queue_single();
      end else begin
         queue_noise();
      end
   endfunction

   initial begin
      int phase;
      int start;
      int budget;
      int set_bs[PHASES];
      int set_st[PHASES];
      int set_max[PHASES];
      int send_max[PHASES];
      int recv_max[PHASES];
      set_bs   = '{1, 0, 255, 2, $urandom_range(1, 16), 8, $urandom_range(0, 255), 0};
      set_st   = '{255, 0, $urandom_range(0, 255), 0, $urandom_range(0, 255), 127,
                   $urandom_range(0, 255), 255};
      set_max  = '{4095, 0, 8, 4095, $urandom_range(64, 300), 300,
                   $urandom_range(8, 300), 4095};
      send_max = '{0, 0, 7, 7, 0, 0, 7, 7};
      recv_max = '{7, 0, 7, 7, 0, 7, 0, 7};
      reset_model();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed frames at the reset settings: ignored frames, malformed frames and
      // every way a reception can be started, broken, restarted and finished.
      queue_frame(64'h0123_4567_89AB_CDEF, 4'd0);
      queue_frame({PCI_FLOW, 4'h0, 8'h08, 8'h14, 40'hFF_FFFF_FFFF}, 4'd3);
      queue_frame('1, 4'd8);
      queue_frame('0, 4'd8);
      queue_frame({PCI_SINGLE, 4'd7, {7{8'hFF}}}, 4'd8);
      queue_frame({PCI_SINGLE, 4'd8, 56'h11_2233_4455_6677}, 4'd8);
      queue_frame({PCI_SINGLE, 4'd5, 56'hAB_CDEF_0123_4567}, 4'd5);
      queue_frame({PCI_SINGLE, 4'd1, 56'hA5_5A5A_5A5A_5A5A}, 4'd15);
      queue_frame(consec_frame(4'd1), 4'd8);
      queue_frame(first_frame(100), 4'd7);
      queue_frame(first_frame(7), 4'd8);
      queue_frame(first_frame(4095), 4'd8);
      queue_frame(first_frame(20), 4'd8);
      queue_frame(consec_frame(4'd1), 4'd3);
      queue_frame(consec_frame(4'd1), 4'd8);
      queue_frame({PCI_FLOW, 4'h1, 48'h0, 8'h00}, 4'd8);
      queue_frame({PCI_SINGLE, 4'd3, 56'hC0_FFEE_0000_0000}, 4'd4);
      queue_frame(first_frame(8), 4'd8);
      queue_frame(consec_frame(4'd1), 4'd3);
      queue_frame(first_frame(10), 4'd8);
      queue_frame(consec_frame(4'd2), 4'd8);
      drain();

      // Overflow just above the limit, and overflow in the middle of a reception.
      write_register(CSR_MAX_LEN, 12'd100);
      settings_used++;
      queue_frame(first_frame(101), 4'd8);
      queue_frame(first_frame(50), 4'd8);
      queue_frame(first_frame(4095), 4'd8);
      queue_frame(consec_frame(4'd1), 4'd8);
      drain();

      // Random phases, each under its own register settings; drain half-way through so
      // the sender waits for every result before carrying on.
      for (phase = 0; phase < PHASES; phase++) begin
         write_register(CSR_BLOCK_SIZE, 12'(set_bs[phase]));
         write_register(CSR_SEP_TIME, 12'(set_st[phase]));
         write_register(CSR_MAX_LEN, 12'(set_max[phase]));
         settings_used++;
         sender_gap_max = send_max[phase];
         receiver_gap_max = recv_max[phase];
         if (phase == 0) begin
            // hold the receiver off while a full-length message streams in
            hold_requests++;
            queue_message(4095, 1'b1);
         end
         budget = (phase == 0) ? 100 : 160;
         repeat (2) begin
            start = frames_queued;
            while (frames_queued - start < budget / 2) queue_mixed();
            drain();
         end
      end

      if (expected_results.size() != 0) begin
         report_mismatch("results never delivered", 64'(expected_results.size()), '0);
      end
      $display("Covered %0d frames under %0d register settings: %0d results, %0d whole messages,",
               frames_accepted, settings_used, results_checked, messages_done);
      $display("%0d flow-control requests, %0d sequence / %0d overflow / %0d invalid errors.",
               fc_requests, error_tally[ERR_SEQ], error_tally[ERR_OVF],
               error_tally[ERR_INVALID]);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
